@@ rtl/core/drne_pkg.sv @@
// ----------------------------------------------------------------------------
// drne_pkg
// Shared constants, register codes and controller/datapath types for the
// depth range normalize and encode unit.
// ----------------------------------------------------------------------------
package drne_pkg;

    localparam int MAX_PIXELS_DEF  = 524288;
    localparam int SAMPLE_BITS_DEF = 24;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;
    localparam int FRAME_W    = 20;
    localparam int FAR_W      = 16;
    localparam int SMOOTH_W   = 16;
    localparam int ENC_W      = 16;
    localparam int RECIP_W    = 32;
    localparam int REM_W      = 49;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_PIXELS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FAR_PLANE       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_SMOOTHING = 2'd2;

    localparam logic [FRAME_W-1:0]  FRAME_PIXELS_RST = 20'd268324;
    localparam logic [FAR_W-1:0]    FAR_PLANE_RST    = 16'd1000;
    localparam logic [SMOOTH_W-1:0] SMOOTHING_RST    = 16'd13107;

    localparam logic [16:0]      ONE_Q16    = 17'h10000;
    localparam logic [ENC_W-1:0] ENC_FAR    = 16'hFFFF;

    localparam logic [4:0] ENC_DIV_LAST = 5'd16;
    localparam logic [4:0] RCP_DIV_LAST = 5'd31;

    typedef struct packed {
        logic accept;
        logic store_wr;
        logic norm;
        logic cmp;
        logic mul_hi;
        logic mul_lo;
        logic tsum;
        logic enc;
        logic div_start_enc;
        logic div_start_rcp;
        logic div_step;
        logic out_load;
        logic blend_diff;
        logic blend_mul;
        logic blend_add;
        logic width_upd;
        logic recip_load;
    } drne_cmd_t;

    typedef struct packed {
        logic vflag;
        logic last;
        logic out_busy;
    } drne_status_t;

endpackage

@@ rtl/core/drne_if.sv @@
// ----------------------------------------------------------------------------
// drne interfaces
// Sample, result and configuration channels of the depth encode unit.
// ----------------------------------------------------------------------------
interface drne_sample_if #(
    parameter int SAMPLE_BITS = drne_pkg::SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] inverse_depth;

    modport source (output valid, output inverse_depth, input ready);
    modport sink   (input valid, input inverse_depth, output ready);
    modport mon    (input valid, input inverse_depth, input ready);
endinterface

interface drne_result_if;
    logic                       valid;
    logic                       ready;
    logic [drne_pkg::ENC_W-1:0] encoded_depth;
    logic                       frame_end;
    logic                       estimate_valid;

    modport source (output valid, output encoded_depth, output frame_end,
                    output estimate_valid, input ready);
    modport sink   (input valid, input encoded_depth, input frame_end,
                    input estimate_valid, output ready);
    modport mon    (input valid, input encoded_depth, input frame_end,
                    input estimate_valid, input ready);
endinterface

interface drne_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [drne_pkg::CFG_IDX_W-1:0]  index;
    logic [drne_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
    modport mon    (input valid, input index, input data, input ready);
endinterface

@@ rtl/core/depth_range_normalize_encode_unit.sv @@
// ----------------------------------------------------------------------------
// depth_range_normalize_encode_unit
// Frame-delayed inverse-depth normalization with a smoothed range and a
// non-linear depth encoding, Q0.16 output.
// ----------------------------------------------------------------------------
// One sample is handled at a time. While no range exists yet, a sample only
// passes the store access and the output load; once it does, it also passes
// the compare, the multiply, the encode setup and the bit-serial restoring
// divider, which runs 17 steps for the encode quotient. The last pixel of a
// frame adds the range blend and the reciprocal of the range width, with 32
// divider steps. The frame store is read and then written once per sample.
// The next sample is taken only after the previous result has left the output
// register, and configuration writes are taken only while no sample is in
// progress. Each result carries the stored sample of the same position from
// the previous frame; until a frame has completed, results are the far plane.
module depth_range_normalize_encode_unit #(
    parameter int MAX_PIXELS  = drne_pkg::MAX_PIXELS_DEF,
    parameter int SAMPLE_BITS = drne_pkg::SAMPLE_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    drne_sample_if.sink  samples,
    drne_result_if.source results,
    drne_cfg_if.sink     cfg
);

    drne_pkg::drne_cmd_t    cmd;
    drne_pkg::drne_status_t status;
    logic                   in_ready;
    logic                   cfg_ready;

    drne_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (samples.valid),
        .in_ready  (in_ready),
        .cfg_valid (cfg.valid),
        .cfg_ready (cfg_ready),
        .status    (status),
        .cmd       (cmd)
    );

    drne_datapath #(
        .MAX_PIXELS  (MAX_PIXELS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .sample_in      (samples.inverse_depth),
        .cfg_wr         (cfg.valid && cfg_ready),
        .cfg_index      (cfg.index),
        .cfg_data       (cfg.data),
        .out_ready      (results.ready),
        .out_valid      (results.valid),
        .encoded_depth  (results.encoded_depth),
        .frame_end      (results.frame_end),
        .estimate_valid (results.estimate_valid)
    );

    assign samples.ready = in_ready;
    assign cfg.ready     = cfg_ready;

endmodule

@@ rtl/core/drne_ctrl.sv @@
// ----------------------------------------------------------------------------
// drne_ctrl
// Sequencer for one sample: store access, normalize, encode division and,
// on the last pixel of a frame, the range update and reciprocal division.
// ----------------------------------------------------------------------------
module drne_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  drne_pkg::drne_status_t status,
    output drne_pkg::drne_cmd_t    cmd
);

    localparam logic [4:0] ST_IDLE   = 5'd0;
    localparam logic [4:0] ST_RD     = 5'd1;
    localparam logic [4:0] ST_CMP    = 5'd2;
    localparam logic [4:0] ST_MULH   = 5'd3;
    localparam logic [4:0] ST_MULL   = 5'd4;
    localparam logic [4:0] ST_TSUM   = 5'd5;
    localparam logic [4:0] ST_ENC    = 5'd6;
    localparam logic [4:0] ST_DSE    = 5'd7;
    localparam logic [4:0] ST_DIV    = 5'd8;
    localparam logic [4:0] ST_OUT    = 5'd9;
    localparam logic [4:0] ST_BDIFF  = 5'd10;
    localparam logic [4:0] ST_BMUL   = 5'd11;
    localparam logic [4:0] ST_BADD   = 5'd12;
    localparam logic [4:0] ST_WID    = 5'd13;
    localparam logic [4:0] ST_RSTART = 5'd14;
    localparam logic [4:0] ST_RDIV   = 5'd15;
    localparam logic [4:0] ST_RLOAD  = 5'd16;

    logic [4:0] state_reg;
    logic [4:0] state_next;
    logic [4:0] cnt_reg;
    logic [4:0] cnt_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        cfg_ready  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready  = !status.out_busy;
                cfg_ready = 1'b1;
                if (in_valid && !status.out_busy && !cfg_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_RD;
                end
                else
                begin
                    in_ready = 1'b0;
                end
            end
            ST_RD:
            begin
                cmd.store_wr = 1'b1;
                cmd.norm     = 1'b1;
                state_next   = status.vflag ? ST_CMP : ST_OUT;
            end
            ST_CMP:
            begin
                cmd.cmp    = 1'b1;
                state_next = ST_MULH;
            end
            ST_MULH:
            begin
                cmd.mul_hi = 1'b1;
                state_next = ST_MULL;
            end
            ST_MULL:
            begin
                cmd.mul_lo = 1'b1;
                state_next = ST_TSUM;
            end
            ST_TSUM:
            begin
                cmd.tsum   = 1'b1;
                state_next = ST_ENC;
            end
            ST_ENC:
            begin
                cmd.enc    = 1'b1;
                state_next = ST_DSE;
            end
            ST_DSE:
            begin
                cmd.div_start_enc = 1'b1;
                cnt_next          = drne_pkg::ENC_DIV_LAST;
                state_next        = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg - 5'd1;
                if (cnt_reg == 5'd0)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                cmd.out_load = 1'b1;
                state_next   = status.last ? ST_BDIFF : ST_IDLE;
            end
            ST_BDIFF:
            begin
                cmd.blend_diff = 1'b1;
                state_next     = ST_BMUL;
            end
            ST_BMUL:
            begin
                cmd.blend_mul = 1'b1;
                state_next    = ST_BADD;
            end
            ST_BADD:
            begin
                cmd.blend_add = 1'b1;
                state_next    = ST_WID;
            end
            ST_WID:
            begin
                cmd.width_upd = 1'b1;
                state_next    = ST_RSTART;
            end
            ST_RSTART:
            begin
                cmd.div_start_rcp = 1'b1;
                cnt_next          = drne_pkg::RCP_DIV_LAST;
                state_next        = ST_RDIV;
            end
            ST_RDIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg - 5'd1;
                if (cnt_reg == 5'd0)
                begin
                    state_next = ST_RLOAD;
                end
            end
            ST_RLOAD:
            begin
                cmd.recip_load = 1'b1;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

@@ rtl/core/drne_datapath.sv @@
// ----------------------------------------------------------------------------
// drne_datapath
// Frame store, frame extremes, smoothed range, shared restoring divider and
// the output register of the depth encode unit.
// ----------------------------------------------------------------------------
module drne_datapath #(
    parameter int MAX_PIXELS  = drne_pkg::MAX_PIXELS_DEF,
    parameter int SAMPLE_BITS = drne_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  drne_pkg::drne_cmd_t                 cmd,
    output drne_pkg::drne_status_t              status,
    input  logic signed [SAMPLE_BITS-1:0]       sample_in,
    input  logic                                cfg_wr,
    input  logic [drne_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [drne_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic [drne_pkg::ENC_W-1:0]          encoded_depth,
    output logic                                frame_end,
    output logic                                estimate_valid
);

    localparam int S     = SAMPLE_BITS;
    localparam int SW    = S + 16;
    localparam int AW    = $clog2(MAX_PIXELS);
    localparam int PW    = $clog2(MAX_PIXELS + 1);
    localparam int CW    = (PW > drne_pkg::FRAME_W) ? PW : drne_pkg::FRAME_W;
    localparam int DW    = (SW + 1 > 34) ? SW + 1 : 34;
    localparam int DSHW  = DW + drne_pkg::RECIP_W - 1;
    localparam int REMW  = drne_pkg::REM_W;
    localparam int PRW   = SW + 17;
    localparam int TW    = SW + 33;
    localparam int P1W   = S + 18;

    // configuration registers
    logic [drne_pkg::FRAME_W-1:0]  frame_pixels_reg;
    logic [drne_pkg::FAR_W-1:0]    far_reg;
    logic [drne_pkg::SMOOTH_W-1:0] smooth_reg;

    // frame bookkeeping
    logic [PW-1:0]        pos_reg;
    logic [AW-1:0]        addr_reg;
    logic [S-1:0]         wdata_reg;
    logic                 last_reg;
    logic                 vflag_reg;
    logic signed [S-1:0]  flow_reg;
    logic signed [S-1:0]  fhigh_reg;

    // range state
    logic signed [SW-1:0] slo_reg;
    logic signed [SW-1:0] shi_reg;
    logic                 rvalid_reg;
    logic [drne_pkg::RECIP_W-1:0] recip_reg;
    logic [SW:0]          width_reg;

    // frame store
    logic [S-1:0] mem [MAX_PIXELS];
    logic [S-1:0] rdata_reg;

    // encode path
    logic signed [SW+1:0] d_reg;
    logic                 le_reg;
    logic                 ge_reg;
    logic [PRW-1:0]       ph_reg;
    logic [PRW-1:0]       pl_reg;
    logic [16:0]          lin_reg;
    logic [REMW-1:0]      num_reg;
    logic [DW-1:0]        den_reg;

    // divider
    logic [REMW-1:0]      rem_reg;
    logic [DSHW-1:0]      dsh_reg;
    logic [drne_pkg::RECIP_W-1:0] q_reg;

    // blend
    logic signed [SW-1:0] curlo_reg;
    logic signed [SW-1:0] curhi_reg;
    logic signed [SW:0]   dlo_reg;
    logic signed [SW:0]   dhi_reg;
    logic signed [P1W-1:0] p1lo_reg;
    logic signed [P1W-1:0] p1hi_reg;
    logic [31:0]          p2lo_reg;
    logic [31:0]          p2hi_reg;

    // output register
    logic                 out_valid_reg;
    logic [drne_pkg::ENC_W-1:0] enc_reg;
    logic                 fe_reg;
    logic                 ev_reg;

    // combinational
    logic [CW-1:0]        fp_ext;
    logic [PW-1:0]        n_eff;
    logic [PW-1:0]        pos_cur;
    logic                 last_cur;
    logic [PW:0]          pos_inc;
    logic signed [SW+1:0] samp_sh;
    logic signed [SW+1:0] d_next;
    logic [TW-1:0]        prod_w;
    logic [TW-1:0]        tq;
    logic [16:0]          t_val;
    logic [drne_pkg::FAR_W-1:0] f_eff;
    logic [32:0]          lf;
    logic [DW-1:0]        den_next;
    logic                 div_ge;
    logic [DSHW-1:0]      rem_ext;
    logic signed [SW-1:0] tlo;
    logic signed [SW-1:0] thi;
    logic signed [SW-1:0] curlo;
    logic signed [SW-1:0] curhi;
    logic signed [SW+1:0] newlo;
    logic signed [SW+1:0] newhi;
    logic signed [SW:0]   wdiff;
    logic [SW:0]          width_next;
    logic [drne_pkg::ENC_W-1:0] enc_next;

    always_comb
    begin
        fp_ext = CW'(frame_pixels_reg);
        if (fp_ext == '0)
        begin
            n_eff = PW'(1);
        end
        else if (fp_ext > CW'(MAX_PIXELS))
        begin
            n_eff = PW'(MAX_PIXELS);
        end
        else
        begin
            n_eff = PW'(fp_ext);
        end
        pos_cur  = (pos_reg >= n_eff) ? '0 : pos_reg;
        pos_inc  = {1'b0, pos_cur} + (PW+1)'(1);
        last_cur = (pos_inc == {1'b0, n_eff});
    end

    // Normalize: sample scaled to 16 fraction bits, offset by the range floor.
    always_comb
    begin
        samp_sh = $signed({{(SW+2-S){rdata_reg[S-1]}}, rdata_reg}) <<< 16;
        d_next  = samp_sh - $signed({{2{slo_reg[SW-1]}}, slo_reg});
    end

    always_comb
    begin
        prod_w = (TW'(ph_reg) << 16) + TW'(pl_reg);
        tq     = prod_w >> 31;
        if (le_reg)
        begin
            t_val = '0;
        end
        else if (ge_reg || (tq > TW'(drne_pkg::ONE_Q16)))
        begin
            t_val = drne_pkg::ONE_Q16;
        end
        else
        begin
            t_val = tq[16:0];
        end
    end

    always_comb
    begin
        f_eff    = (far_reg == '0) ? drne_pkg::FAR_W'(1) : far_reg;
        lf       = 33'(lin_reg) * 33'(f_eff);
        den_next = DW'(drne_pkg::ONE_Q16)
                 + DW'(DW'(lin_reg) * DW'(f_eff - drne_pkg::FAR_W'(1)));
    end

    always_comb
    begin
        rem_ext = DSHW'(rem_reg);
        div_ge  = (rem_ext >= dsh_reg);
    end

    always_comb
    begin
        tlo   = $signed({flow_reg, 16'h0000});
        thi   = $signed({fhigh_reg, 16'h0000});
        curlo = rvalid_reg ? slo_reg : tlo;
        curhi = rvalid_reg ? shi_reg : thi;
        newlo = $signed({{2{curlo_reg[SW-1]}}, curlo_reg})
              + p1lo_reg
              + $signed({2'b00, SW'(p2lo_reg[31:16])});
        newhi = $signed({{2{curhi_reg[SW-1]}}, curhi_reg})
              + p1hi_reg
              + $signed({2'b00, SW'(p2hi_reg[31:16])});
        wdiff = $signed({shi_reg[SW-1], shi_reg}) - $signed({slo_reg[SW-1], slo_reg});
        if (wdiff < $signed((SW+1)'(65536)))
        begin
            width_next = (SW+1)'(65536);
        end
        else
        begin
            width_next = wdiff[SW:0];
        end
    end

    always_comb
    begin
        if (!vflag_reg)
        begin
            enc_next = drne_pkg::ENC_FAR;
        end
        else if (q_reg > 32'(drne_pkg::ENC_FAR))
        begin
            enc_next = drne_pkg::ENC_FAR;
        end
        else
        begin
            enc_next = q_reg[drne_pkg::ENC_W-1:0];
        end
    end

    // Store: registered read at accept, write of the new sample in the cycle after.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            rdata_reg <= mem[pos_cur[AW-1:0]];
        end
        if (cmd.store_wr)
        begin
            mem[addr_reg] <= wdata_reg;
        end
    end

    // Control state and range state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_pixels_reg <= drne_pkg::FRAME_PIXELS_RST;
            far_reg          <= drne_pkg::FAR_PLANE_RST;
            smooth_reg       <= drne_pkg::SMOOTHING_RST;
            pos_reg          <= '0;
            flow_reg         <= '0;
            fhigh_reg        <= '0;
            slo_reg          <= '0;
            shi_reg          <= SW'(1) << 24;
            rvalid_reg       <= 1'b0;
            recip_reg        <= '0;
            width_reg        <= (SW+1)'(1) << 24;
            out_valid_reg    <= 1'b0;
            last_reg         <= 1'b0;
            vflag_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                case (cfg_index)
                    drne_pkg::CFG_FRAME_PIXELS:
                    begin
                        frame_pixels_reg <= cfg_data[drne_pkg::FRAME_W-1:0];
                        pos_reg          <= '0;
                        flow_reg         <= '0;
                        fhigh_reg        <= '0;
                        slo_reg          <= '0;
                        shi_reg          <= SW'(1) << 24;
                        rvalid_reg       <= 1'b0;
                        recip_reg        <= '0;
                        width_reg        <= (SW+1)'(1) << 24;
                    end
                    drne_pkg::CFG_FAR_PLANE:
                    begin
                        far_reg <= cfg_data[drne_pkg::FAR_W-1:0];
                    end
                    drne_pkg::CFG_RANGE_SMOOTHING:
                    begin
                        smooth_reg <= cfg_data[drne_pkg::SMOOTH_W-1:0];
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.accept)
            begin
                last_reg  <= last_cur;
                vflag_reg <= rvalid_reg;
                pos_reg   <= last_cur ? '0 : pos_inc[PW-1:0];
                if (pos_cur == '0)
                begin
                    flow_reg  <= sample_in;
                    fhigh_reg <= sample_in;
                end
                else
                begin
                    if (sample_in < flow_reg)
                    begin
                        flow_reg <= sample_in;
                    end
                    if (sample_in > fhigh_reg)
                    begin
                        fhigh_reg <= sample_in;
                    end
                end
            end
            if (cmd.blend_add)
            begin
                slo_reg    <= newlo[SW-1:0];
                shi_reg    <= newhi[SW-1:0];
                rvalid_reg <= 1'b1;
            end
            if (cmd.width_upd)
            begin
                width_reg <= width_next;
            end
            if (cmd.recip_load)
            begin
                recip_reg <= q_reg;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            addr_reg  <= pos_cur[AW-1:0];
            wdata_reg <= sample_in;
        end
        if (cmd.norm)
        begin
            d_reg <= d_next;
        end
        if (cmd.cmp)
        begin
            le_reg <= d_reg[SW+1] || (d_reg == '0);
            ge_reg <= !d_reg[SW+1] && (d_reg[SW:0] >= width_reg);
        end
        if (cmd.mul_hi)
        begin
            ph_reg <= PRW'(d_reg[SW:0]) * PRW'(recip_reg[31:16]);
        end
        if (cmd.mul_lo)
        begin
            pl_reg <= PRW'(d_reg[SW:0]) * PRW'(recip_reg[15:0]);
        end
        if (cmd.tsum)
        begin
            lin_reg <= drne_pkg::ONE_Q16 - t_val;
        end
        if (cmd.enc)
        begin
            num_reg <= {lf, 16'h0000};
            den_reg <= den_next;
        end
        if (cmd.div_start_enc)
        begin
            rem_reg <= num_reg;
            dsh_reg <= DSHW'(den_reg) << 16;
            q_reg   <= '0;
        end
        else if (cmd.div_start_rcp)
        begin
            rem_reg <= REMW'(1) << 47;
            dsh_reg <= DSHW'(width_reg) << 31;
            q_reg   <= '0;
        end
        else if (cmd.div_step)
        begin
            if (div_ge)
            begin
                rem_reg <= REMW'(rem_ext - dsh_reg);
            end
            q_reg   <= {q_reg[drne_pkg::RECIP_W-2:0], div_ge};
            dsh_reg <= dsh_reg >> 1;
        end
        if (cmd.blend_diff)
        begin
            curlo_reg <= curlo;
            curhi_reg <= curhi;
            dlo_reg   <= $signed({tlo[SW-1], tlo}) - $signed({curlo[SW-1], curlo});
            dhi_reg   <= $signed({thi[SW-1], thi}) - $signed({curhi[SW-1], curhi});
        end
        if (cmd.blend_mul)
        begin
            p1lo_reg <= $signed({{17{dlo_reg[SW]}}, dlo_reg[SW:16]})
                      * $signed({{(P1W-17){1'b0}}, 1'b0, smooth_reg});
            p1hi_reg <= $signed({{17{dhi_reg[SW]}}, dhi_reg[SW:16]})
                      * $signed({{(P1W-17){1'b0}}, 1'b0, smooth_reg});
            p2lo_reg <= 32'(dlo_reg[15:0]) * 32'(smooth_reg);
            p2hi_reg <= 32'(dhi_reg[15:0]) * 32'(smooth_reg);
        end
        if (cmd.out_load)
        begin
            enc_reg <= enc_next;
            fe_reg  <= last_reg;
            ev_reg  <= vflag_reg;
        end
    end

    assign status.vflag    = vflag_reg;
    assign status.last     = last_reg;
    assign status.out_busy = out_valid_reg;

    assign out_valid      = out_valid_reg;
    assign encoded_depth  = enc_reg;
    assign frame_end      = fe_reg;
    assign estimate_valid = ev_reg;

endmodule

@@ rtl/core/drne_checker.sv @@
// ----------------------------------------------------------------------------
// drne_checker
// Port-level checks of the depth encode unit, bound to the top level.
// ----------------------------------------------------------------------------
module drne_checker (
    input logic           clk,
    input logic           rst_n,
    drne_sample_if.sink   samples,
    drne_result_if.source results,
    drne_cfg_if.sink      cfg
);

    // A pending result holds until the transfer completes.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && !results.ready |=> results.valid)
        else $error("result dropped before transfer");

    // Without a range estimate the result is the far plane.
    a_filler: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && !results.estimate_valid |->
        results.encoded_depth == drne_pkg::ENC_FAR)
        else $error("filler result is not far plane");

    // Samples are processed one at a time.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        samples.valid && samples.ready |=> !samples.ready)
        else $error("sample taken while previous one in progress");

    // A sample is never taken while a result still waits.
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        samples.ready |-> !results.valid)
        else $error("sample taken with result pending");

    // Configuration and sample transfers never coincide.
    a_cfg_excl: assert property (@(posedge clk) disable iff (!rst_n)
        cfg.valid && cfg.ready |-> !(samples.valid && samples.ready))
        else $error("configuration write during sample transfer");

endmodule

bind depth_range_normalize_encode_unit drne_checker u_drne_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .samples (samples),
    .results (results),
    .cfg     (cfg)
);

@@ tb/sv/tb_depth_range_normalize_encode_unit.sv @@
// ----------------------------------------------------------------------------
// tb_depth_range_normalize_encode_unit
// Self-checking bench for the depth range normalize and encode unit. Frames
// of inverse-depth samples go in under random flow control. A depth encoder
// model predicts every result and compares it field by field in order.
// ----------------------------------------------------------------------------
module tb_depth_range_normalize_encode_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  SAMPLES_TARGET = 1500;
    localparam int  QUIET_AFTER    = 1250;
    localparam int  SETTLE_CYCLES  = 80;
    localparam int  CYCLE_LIMIT    = 3000000;
    localparam int  STORE_DEPTH    = drne_pkg::MAX_PIXELS_DEF;
    localparam int  SAMPLE_W       = drne_pkg::SAMPLE_BITS_DEF;
    localparam int  DATA_W         = drne_pkg::CFG_DATA_W;

    typedef struct {
        logic [drne_pkg::ENC_W-1:0] encoded_depth;
        logic                       frame_end;
        logic                       estimate_valid;
    } depth_result_t;

    class depth_encoder_model;
        logic [SAMPLE_W-1:0] store [int];
        int unsigned    position;
        longint         cur_low, cur_high, sm_low, sm_high;
        bit             have_range;
        longint         reciprocal;
        int unsigned    pixels, far_dist, smoothing;
        depth_result_t  pending [$];
        int             errors;

        function void clear_range();
            position   = 0;
            cur_low    = 0;
            cur_high   = 0;
            sm_low     = 0;
            sm_high    = longint'(1) << 24;
            have_range = 0;
            reciprocal = 0;
        endfunction

        function void init();
            pixels    = 32'(drne_pkg::FRAME_PIXELS_RST);
            far_dist  = 32'(drne_pkg::FAR_PLANE_RST);
            smoothing = 32'(drne_pkg::SMOOTHING_RST);
            errors    = 0;
            clear_range();
        endfunction

        function void write_reg(logic [drne_pkg::CFG_IDX_W-1:0] idx,
                                logic [drne_pkg::CFG_DATA_W-1:0] value);
            case (idx)
                drne_pkg::CFG_FRAME_PIXELS:
                begin
                    pixels = 32'(value);
                    clear_range();
                end
                drne_pkg::CFG_FAR_PLANE:       far_dist  = 32'(value[drne_pkg::FAR_W-1:0]);
                drne_pkg::CFG_RANGE_SMOOTHING: smoothing = 32'(value[drne_pkg::SMOOTH_W-1:0]);
                default: ;
            endcase
        endfunction

        function longint span();
            longint w;
            w = sm_high - sm_low;
            return (w < 65536) ? 65536 : w;
        endfunction

        // Fractional part is split off so the product cannot overflow.
        function longint blend(longint cur, longint target);
            longint diff, q, r;
            diff = target - cur;
            q = diff >>> 16;
            r = diff - q * 65536;
            return cur + q * smoothing + ((r * smoothing) >> 16);
        endfunction

        function logic [drne_pkg::ENC_W-1:0] encode(longint sample);
            longint w, d, t, lin, f, num, den, e;
            w = span();
            d = sample * 65536 - sm_low;
            if (d <= 0)
                t = 0;
            else if (d >= w)
                t = 65536;
            else
            begin
                t = (d * reciprocal) >> 31;
                if (t > 65536)
                    t = 65536;
            end
            lin = 65536 - t;
            f   = (far_dist == 0) ? 1 : far_dist;
            num = lin * f * 65536;
            den = 65536 + lin * (f - 1);
            e   = num / den;
            return (e > 65535) ? 16'hFFFF : e[drne_pkg::ENC_W-1:0];
        endfunction

        function void note_sample(logic signed [SAMPLE_W-1:0] raw);
            int unsigned   n, pos;
            longint        s;
            bit            last;
            depth_result_t r;
            n = (pixels == 0) ? 1 : ((pixels > STORE_DEPTH) ? STORE_DEPTH : pixels);
            pos = (position >= n) ? 0 : position;
            s = raw;
            last = (pos + 1 == n);
            r.encoded_depth  = drne_pkg::ENC_FAR;
            r.frame_end      = last;
            r.estimate_valid = have_range;
            if (have_range)
                r.encoded_depth = encode(longint'($signed(store[pos])));
            pending = {pending, r};
            store[pos] = raw;
            if (pos == 0)
            begin
                cur_low  = s;
                cur_high = s;
            end
            else
            begin
                if (s < cur_low)
                    cur_low = s;
                if (s > cur_high)
                    cur_high = s;
            end
            if (last)
            begin
                if (!have_range)
                begin
                    sm_low     = cur_low * 65536;
                    sm_high    = cur_high * 65536;
                    have_range = 1;
                end
                sm_low     = blend(sm_low, cur_low * 65536);
                sm_high    = blend(sm_high, cur_high * 65536);
                reciprocal = (longint'(1) << 47) / span();
                position   = 0;
            end
            else
                position = pos + 1;
        endfunction

        function void check_result(logic [drne_pkg::ENC_W-1:0] enc, logic fe, logic ev);
            depth_result_t r;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result enc=%0d frame_end=%0b estimate_valid=%0b",
                         $time, enc, fe, ev);
                errors++;
                return;
            end
            r = pending.pop_front();
            if (enc !== r.encoded_depth)
            begin
                $display("%0t: encoded_depth expected %0d actual %0d",
                         $time, r.encoded_depth, enc);
                errors++;
            end
            if (fe !== r.frame_end)
            begin
                $display("%0t: frame_end expected %0b actual %0b", $time, r.frame_end, fe);
                errors++;
            end
            if (ev !== r.estimate_valid)
            begin
                $display("%0t: estimate_valid expected %0b actual %0b",
                         $time, r.estimate_valid, ev);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   cycles;
    int   sent;
    bit   quiet;
    int   stall_left;

    depth_encoder_model model;

    drne_sample_if #(.SAMPLE_BITS(SAMPLE_W)) s_if ();
    drne_result_if                           r_if ();
    drne_cfg_if                              c_if ();

    depth_range_normalize_encode_unit u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (s_if),
        .results (r_if),
        .cfg     (c_if)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Result side: check each transfer, then decide on the next stall.
    always @(posedge clk)
    begin
        if (rst_n && r_if.valid && r_if.ready)
            model.check_result(r_if.encoded_depth, r_if.frame_end, r_if.estimate_valid);
        if (stall_left > 0)
        begin
            stall_left--;
            r_if.ready <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 11) == 0)
        begin
            stall_left = $urandom_range(1, 12) - 1;
            r_if.ready <= 1'b0;
        end
        else
            r_if.ready <= 1'b1;
    end

    // The strobe is dropped after each write before the task returns.
    task automatic write_reg(logic [drne_pkg::CFG_IDX_W-1:0] idx,
                             logic [drne_pkg::CFG_DATA_W-1:0] value);
        c_if.valid <= 1'b1;
        c_if.index <= idx;
        c_if.data  <= value;
        do
            @(posedge clk);
        while (!c_if.ready);
        model.write_reg(idx, value);
        c_if.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic setup(int unsigned px, int unsigned fp, int unsigned sm);
        write_reg(drne_pkg::CFG_FRAME_PIXELS, DATA_W'(px));
        write_reg(drne_pkg::CFG_FAR_PLANE, DATA_W'(fp));
        write_reg(drne_pkg::CFG_RANGE_SMOOTHING, DATA_W'(sm));
    endtask

    // Called at a clock edge; returns at the edge of the transfer, or after a random gap with valid low.
    task automatic send_sample(logic signed [SAMPLE_W-1:0] value);
        int gap;
        s_if.valid         <= 1'b1;
        s_if.inverse_depth <= value;
        do
            @(posedge clk);
        while (!s_if.ready);
        model.note_sample(value);
        sent++;
        if (sent >= QUIET_AFTER)
            quiet = 1;
        if (!quiet && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 12);
            s_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stops the sender and waits until every expected result has come.
    task automatic drain();
        s_if.valid <= 1'b0;
        while (model.pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic send_frame(int unsigned n);
        int                         mode;
        logic signed [SAMPLE_W-1:0] base;
        int                         spread;
        mode   = $urandom_range(0, 9);
        base   = SAMPLE_W'($urandom);
        spread = $urandom_range(1, 4096);
        for (int i = 0; i < n; i++)
        begin
            if (mode < 5)
                send_sample(SAMPLE_W'(base + $signed($urandom_range(0, spread))
                                      - spread / 2));
            else if (mode < 8)
                send_sample(SAMPLE_W'($urandom));
            else
                send_sample(base);
        end
    endtask

    initial
    begin
        int unsigned n, fp, sm, frames;
        model = new();
        model.init();
        clk = 0;
        rst_n = 0;
        cycles = 0;
        sent = 0;
        quiet = 0;
        stall_left = 0;
        s_if.valid = 0;
        s_if.inverse_depth = '0;
        r_if.ready = 0;
        c_if.valid = 0;
        c_if.index = drne_pkg::CFG_FRAME_PIXELS;
        c_if.data = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A zero frame size behaves as one pixel per frame.
        setup(0, 0, 0);
        send_sample(24'sh000100);
        send_sample(24'sh7FFFFF);
        send_sample(-24'sd1);
        drain();
        // Full-scale extremes, then a flat frame that hits the width floor.
        setup(4, 1, 16'hFFFF);
        send_sample(-24'sd8388608);
        send_sample(24'sd8388607);
        send_sample(24'sd0);
        send_sample(24'sd256);
        send_sample(24'sd0);
        send_sample(-24'sd8388608);
        send_sample(24'sd8388607);
        send_sample(24'sd5);
        for (int i = 0; i < 4; i++)
            send_sample(24'sd77);
        drain();
        setup(4, 65535, 16'h8000);
        for (int i = 0; i < 8; i++)
            send_sample(SAMPLE_W'($urandom));
        drain();
        // Oversized frame sizes saturate; no frame completes here.
        setup(20'hFFFFF, 2, 0);
        send_sample(24'sh123456);
        send_sample(24'shEDCBA9);
        drain();
        write_reg(drne_pkg::CFG_FRAME_PIXELS, DATA_W'(STORE_DEPTH));
        send_sample(24'sh00FF00);
        drain();

        while (sent < SAMPLES_TARGET)
        begin
            case ($urandom_range(0, 9))
                0:       n = 1;
                1:       n = $urandom_range(40, 70);
                default: n = $urandom_range(2, 12);
            endcase
            case ($urandom_range(0, 4))
                0:       fp = 0;
                1:       fp = 65535;
                2:       fp = $urandom_range(1, 3);
                default: fp = $urandom_range(2, 65535);
            endcase
            case ($urandom_range(0, 4))
                0:       sm = 0;
                1:       sm = 65535;
                default: sm = $urandom_range(0, 65535);
            endcase
            setup(n, fp, sm);
            frames = $urandom_range(2, 6);
            for (int k = 0; k < frames; k++)
            begin
                send_frame(n);
                // Occasionally hold the sender until the block has emptied.
                if ($urandom_range(0, 9) == 0)
                begin
                    s_if.valid <= 1'b0;
                    while (model.pending.size() != 0)
                        @(posedge clk);
                end
            end
            drain();
        end

        drain();
        if (model.errors == 0 && model.pending.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
